[hdl/btba_pkg.sv]
// ----------------------------------------------------------------------------
// btba_pkg
// shared types and constants of the boundary tag block allocator
// ----------------------------------------------------------------------------
package btba_pkg;

  localparam int unsigned NumBlocksDef  = 4096;
  localparam int unsigned BlockBytesDef = 64;

  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StZero    = 3'd1;
  localparam logic [2:0] StNoFit   = 3'd2;
  localparam logic [2:0] StNull    = 3'd3;
  localparam logic [2:0] StInvalid = 3'd4;

  localparam logic CmdAlloc = 1'b0;
  localparam logic CmdFree  = 1'b1;

  // memory request from the sequencer to the map store
  typedef struct packed {
    logic        rd;
    logic        wr;
    logic [31:0] addr;
    logic [31:0] wdata;
  } map_req_t;

endpackage

[hdl/boundary_tag_block_allocator.sv]
// ----------------------------------------------------------------------------
// boundary tag block allocator
// first-fit heap allocator over a block map with boundary tags
// ----------------------------------------------------------------------------
// a zero or oversized allocate is answered without a map access; an allocate
// reads the head of each run in turn until one fits, then writes the tags;
// a free rewrites the tags of the run and merges it with free neighbours; one
// request at a time, the next taken from the cycle after the result is accepted, set by the single map port
// reset: the map is rebuilt by a clearing pass over all NumBlocks entries
// after reset, during which no request is taken; heap_base resets to 0
module boundary_tag_block_allocator
  import btba_pkg::*;
#(
  parameter int unsigned NumBlocks  = NumBlocksDef,
  parameter int unsigned BlockBytes = BlockBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [71:0] s_axis_tdata_i,  // command, request_bytes, free_address
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o   // status, block_address, pad
);

  localparam int unsigned EntW = $clog2(NumBlocks + 1) + 2;
  localparam int unsigned IdxW = $clog2(NumBlocks);

  logic [31:0] base_q;
  logic        busy, done, clr, we, start;
  logic [2:0]  status;
  logic [31:0] baddr;
  logic [IdxW-1:0] maddr;
  logic [EntW-1:0] wdata, rdata;
  logic        ovalid_q;
  logic [34:0] odata_q;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) base_q <= '0;
    else if (cfg_valid_i) base_q <= cfg_data_i;
  end

  assign s_axis_tready_o = !busy && !ovalid_q;
  assign start = s_axis_tvalid_i && s_axis_tready_o;

  btba_seq #(.NumBlocks(NumBlocks), .BlockBytes(BlockBytes)) u_seq (
    .clk_i, .rst_ni, .start_i(start), .cmd_i(s_axis_tdata_i[0]),
    .bytes_i(s_axis_tdata_i[32:1]), .addr_i(s_axis_tdata_i[64:33]), .base_i(base_q),
    .busy_o(busy), .done_o(done), .status_o(status), .baddr_o(baddr), .clr_o(clr),
    .we_o(we), .maddr_o(maddr), .wdata_o(wdata), .rdata_i(rdata)
  );

  btba_map_mem #(.NumBlocks(NumBlocks)) u_mem (
    .clk_i, .we_i(we), .addr_i(maddr), .wdata_i(wdata), .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ovalid_q <= 1'b0;
    else if (done) ovalid_q <= 1'b1;
    else if (m_axis_tready_i) ovalid_q <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (done) odata_q <= {baddr, status};
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = {5'd0, odata_q};

  a_no_start_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr |-> !s_axis_tready_o) else $error("request taken during clear");
  a_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done && status != StOk |-> baddr == '0) else $error("address on error");
  a_done_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> !ovalid_q) else $error("result overrun");

endmodule

[hdl/btba_map_mem.sv]
// ----------------------------------------------------------------------------
// btba_map_mem
// block map store, one port, registered read data
// ----------------------------------------------------------------------------
module btba_map_mem
  import btba_pkg::*;
#(
  parameter int unsigned NumBlocks = NumBlocksDef,
  parameter int unsigned EntW      = $clog2(NumBlocks + 1) + 2,
  parameter int unsigned IdxW      = $clog2(NumBlocks)
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [IdxW-1:0] addr_i,
  input  logic [EntW-1:0] wdata_i,
  output logic [EntW-1:0] rdata_o
);

  logic [EntW-1:0] mem_q [NumBlocks];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

[hdl/btba_seq.sv]
// ----------------------------------------------------------------------------
// btba_seq
// sequencer with a shared adder working the block map
// ----------------------------------------------------------------------------
module btba_seq
  import btba_pkg::*;
#(
  parameter int unsigned NumBlocks  = NumBlocksDef,
  parameter int unsigned BlockBytes = BlockBytesDef,
  parameter int unsigned EntW       = $clog2(NumBlocks + 1) + 2,
  parameter int unsigned IdxW       = $clog2(NumBlocks)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            cmd_i,
  input  logic [31:0]     bytes_i,
  input  logic [31:0]     addr_i,
  input  logic [31:0]     base_i,
  output logic            busy_o,
  output logic            done_o,
  output logic [2:0]      status_o,
  output logic [31:0]     baddr_o,
  output logic            clr_o,
  output logic            we_o,
  output logic [IdxW-1:0] maddr_o,
  output logic [EntW-1:0] wdata_o,
  input  logic [EntW-1:0] rdata_i
);

  localparam int unsigned LenW  = EntW - 2;
  localparam int unsigned ShW   = $clog2(BlockBytes);
  localparam logic [LenW-1:0] LenFull = LenW'(NumBlocks);

  localparam logic [4:0] SClr  = 5'd0,  SIdle = 5'd1,  SAStep = 5'd2,  SARd = 5'd3,
                         SAChk = 5'd4,  SAW1  = 5'd5,  SAW2   = 5'd6,  SAW3 = 5'd7,
                         SAW4  = 5'd8,  SAAdr = 5'd9,  SFRd   = 5'd10, SFChk = 5'd11,
                         SFW1  = 5'd12, SFW2  = 5'd13, SFPRd  = 5'd14, SFPChk = 5'd15,
                         SFPW1 = 5'd16, SFPW2 = 5'd17, SFPW3  = 5'd18, SFNRd = 5'd19,
                         SFNChk = 5'd20, SFNW1 = 5'd21, SFNW2 = 5'd22, SFNW3 = 5'd23,
                         SDone = 5'd24, SFPW4 = 5'd25, SFNW4 = 5'd26;

  logic [4:0]      st_q, st_d;
  logic [IdxW:0]   i_q, i_d;       // walk index, also clear index
  logic [IdxW:0]   start_q, start_d;
  logic [IdxW:0]   end_q, end_d;
  logic [LenW:0]   n_q, n_d;       // requested or run length
  logic [LenW:0]   old_q, old_d;
  logic [2:0]      stat_q, stat_d;
  logic [31:0]     ba_q, ba_d;

  // shared adder
  logic [32:0] add_a, add_b, add_s;
  assign add_s = add_a + add_b;

  logic [LenW-1:0] e_len;
  logic            e_head, e_alloc;
  assign e_len   = rdata_i[LenW-1:0];
  assign e_head  = rdata_i[EntW-1];
  assign e_alloc = rdata_i[EntW-2];

  function automatic logic [EntW-1:0] ent(input logic hd, input logic al,
                                          input logic [LenW:0] l);
    ent = {hd, al, l[LenW-1:0]};
  endfunction

  logic [32:0] off;
  assign off = {1'b0, addr_i} - {1'b0, base_i};

  always_comb begin
    st_d = st_q; i_d = i_q; start_d = start_q; end_d = end_q; n_d = n_q;
    old_d = old_q; stat_d = stat_q; ba_d = ba_q;
    we_o = 1'b0; maddr_o = i_q[IdxW-1:0]; wdata_o = '0;
    add_a = '0; add_b = '0;
    case (st_q)
      SClr: begin
        we_o = 1'b1;
        wdata_o = (i_q == '0) ? ent(1'b1, 1'b0, (LenW+1)'(LenFull)) :
                  (i_q == (IdxW+1)'(NumBlocks - 1)) ? ent(1'b0, 1'b0, (LenW+1)'(LenFull))
                  : '0;
        i_d = i_q + 1'b1;
        if (i_q == (IdxW+1)'(NumBlocks - 1)) st_d = SIdle;
      end
      SIdle: begin
        if (start_i) begin
          stat_d = StOk; ba_d = '0; i_d = '0;
          if (cmd_i == CmdAlloc) begin
            add_a = {1'b0, bytes_i};
            add_b = 33'(BlockBytes - 1);
            if (bytes_i == '0) begin
              stat_d = StZero; st_d = SDone;
            end else if ((add_s >> ShW) > 33'(NumBlocks)) begin
              stat_d = StNoFit; st_d = SDone;
            end else begin
              n_d = (LenW+1)'(add_s >> ShW); st_d = SARd;
            end
          end else begin
            stat_d = StInvalid; st_d = SDone;
            if (addr_i == '0) stat_d = StNull;
            else if (!off[32] && off[ShW-1:0] == '0 &&
                     (off[31:0] >> ShW) < 32'(NumBlocks)) begin
              i_d = (IdxW+1)'(off[31:0] >> ShW); st_d = SFRd;
            end
          end
        end
      end
      SARd: st_d = SAChk;  // address i presented, data next cycle
      SAChk: begin
        add_a = 33'(i_q);
        add_b = (e_len != '0) ? 33'(e_len) : 33'd1;
        if (!e_alloc && (LenW+1)'(e_len) >= n_q) begin
          old_d = (LenW+1)'(e_len); st_d = SAW1;
        end else begin
          i_d = (IdxW+1)'(add_s);
          if (add_s >= 33'(NumBlocks)) begin
            stat_d = StNoFit; st_d = SDone;
          end else st_d = SARd;
        end
      end
      SAW1: begin
        we_o = 1'b1; wdata_o = ent(1'b1, 1'b1, n_q);
        add_a = 33'(i_q); add_b = 33'(n_q);
        end_d = (IdxW+1)'(add_s - 33'd1);
        start_d = (IdxW+1)'(add_s);
        st_d = (n_q > 1) ? SAW2 : SAW3;
      end
      SAW2: begin
        maddr_o = end_q[IdxW-1:0]; we_o = 1'b1; wdata_o = ent(1'b0, 1'b1, n_q);
        st_d = SAW3;
      end
      SAW3: begin
        add_a = 33'(old_q); add_b = ~33'(n_q) + 33'd1;
        if (old_q > n_q) begin
          maddr_o = start_q[IdxW-1:0]; we_o = 1'b1;
          wdata_o = ent(1'b1, 1'b0, (LenW+1)'(add_s));
          old_d = (LenW+1)'(add_s);
          st_d = SAW4;
        end else st_d = SAAdr;
      end
      SAW4: begin
        add_a = 33'(start_q); add_b = 33'(old_q) - 33'd1;
        maddr_o = add_s[IdxW-1:0];
        if (old_q > 1) begin
          we_o = 1'b1; wdata_o = ent(1'b0, 1'b0, old_q);
        end
        st_d = SAAdr;
      end
      SAAdr: begin
        add_a = {1'b0, base_i}; add_b = 33'(i_q) << ShW;
        ba_d = add_s[31:0]; st_d = SDone;
      end
      SFRd: st_d = SFChk;
      SFChk: begin
        add_a = 33'(i_q); add_b = 33'(e_len) - 33'd1;
        if (e_head && e_alloc && e_len != '0) begin
          n_d = (LenW+1)'(e_len); start_d = i_q; end_d = (IdxW+1)'(add_s);
          stat_d = StOk; st_d = SFW1;
        end else st_d = SDone;
      end
      SFW1: begin
        we_o = 1'b1; wdata_o = ent(1'b1, 1'b0, n_q);
        st_d = (n_q > 1) ? SFW2 : SFPRd;
      end
      SFW2: begin
        maddr_o = end_q[IdxW-1:0]; we_o = 1'b1; wdata_o = ent(1'b0, 1'b0, n_q);
        st_d = SFPRd;
      end
      SFPRd: begin
        maddr_o = IdxW'(i_q - 1'b1);
        st_d = (i_q != '0) ? SFPChk : SFNRd;
      end
      SFPChk: begin
        add_a = 33'(e_len); add_b = 33'(n_q);
        maddr_o = IdxW'(i_q - 1'b1);
        if (!e_alloc) begin
          if (e_len == '0 || 33'(e_len) > 33'(i_q)) begin
            stat_d = StInvalid; st_d = SDone;
          end else begin
            old_d = (LenW+1)'(e_len); n_d = (LenW+1)'(add_s);
            start_d = i_q - (IdxW+1)'(e_len);
            st_d = SFPW1;
          end
        end else st_d = SFNRd;
      end
      SFPW1: begin
        maddr_o = start_q[IdxW-1:0]; we_o = 1'b1; wdata_o = ent(1'b1, 1'b0, n_q);
        st_d = SFPW2;
      end
      SFPW2: begin
        maddr_o = IdxW'(i_q - 1'b1);
        we_o = (old_q > 1); wdata_o = '0; st_d = SFPW3;
      end
      SFPW3: begin
        we_o = 1'b1; wdata_o = '0; st_d = SFPW4;  // old head at i cleared
      end
      SFPW4: begin
        maddr_o = end_q[IdxW-1:0]; we_o = 1'b1; wdata_o = ent(1'b0, 1'b0, n_q);
        st_d = SFNRd;
      end
      SFNRd: begin
        add_a = 33'(end_q); add_b = 33'd1;
        maddr_o = add_s[IdxW-1:0];
        st_d = (add_s < 33'(NumBlocks)) ? SFNChk : SDone;
      end
      SFNChk: begin
        add_a = 33'(end_q) - 33'(start_q) + 33'd1; add_b = 33'(e_len);
        maddr_o = IdxW'(end_q + 1'b1);
        if (!e_alloc && e_len != '0) begin
          old_d = (LenW+1)'(e_len); n_d = (LenW+1)'(add_s); st_d = SFNW1;
        end else st_d = SDone;
      end
      SFNW1: begin
        add_a = 33'(end_q); add_b = 33'(old_q);
        maddr_o = add_s[IdxW-1:0]; we_o = 1'b1; wdata_o = ent(1'b0, 1'b0, n_q);
        st_d = SFNW2;
      end
      SFNW2: begin
        maddr_o = IdxW'(end_q + 1'b1);
        we_o = (old_q > 1); wdata_o = '0; st_d = SFNW3;
      end
      SFNW3: begin
        maddr_o = end_q[IdxW-1:0]; we_o = 1'b1; wdata_o = '0;
        st_d = SFNW4;
      end
      SFNW4: begin
        // the start head gets the final length after a forward merge
        maddr_o = start_q[IdxW-1:0]; we_o = 1'b1; wdata_o = ent(1'b1, 1'b0, n_q);
        st_d = SDone;
      end
      SDone: st_d = SIdle;
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SClr; i_q <= '0;
    end else begin
      st_q <= st_d;
      i_q  <= i_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q <= start_d; end_q <= end_d; n_q <= n_d; old_q <= old_d;
    stat_q <= stat_d; ba_q <= ba_d;
  end

  assign busy_o   = (st_q != SIdle);
  assign done_o   = (st_q == SDone);
  assign status_o = stat_q;
  assign baddr_o  = ba_q;
  assign clr_o    = (st_q == SClr);

endmodule
